// File: hw/rtl/dses_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dses_pkg
// Shared types, opcodes and sizes for the expression stack evaluator.
// ----------------------------------------------------------------------------
package dses_pkg;

  localparam int STACK_DEPTH   = 64;
  localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W        = $clog2(STACK_DEPTH);
  localparam int VALUE_W       = 64;
  localparam int COUNT_W       = 7;
  localparam int FAULT_W       = 2;
  localparam int CFG_INDEX_W   = 1;

  // opcode bytes
  localparam logic [7:0] OP_ADDR           = 8'h03;
  localparam logic [7:0] OP_CONST1U        = 8'h08;
  localparam logic [7:0] OP_CONSTS         = 8'h11;
  localparam logic [7:0] OP_DUP            = 8'h12;
  localparam logic [7:0] OP_DROP           = 8'h13;
  localparam logic [7:0] OP_OVER           = 8'h14;
  localparam logic [7:0] OP_SWAP           = 8'h16;
  localparam logic [7:0] OP_AND            = 8'h1a;
  localparam logic [7:0] OP_MINUS          = 8'h1c;
  localparam logic [7:0] OP_MUL            = 8'h1e;
  localparam logic [7:0] OP_NEG            = 8'h1f;
  localparam logic [7:0] OP_NOT            = 8'h20;
  localparam logic [7:0] OP_OR             = 8'h21;
  localparam logic [7:0] OP_PLUS           = 8'h22;
  localparam logic [7:0] OP_PLUS_UCONST    = 8'h23;
  localparam logic [7:0] OP_XOR            = 8'h27;
  localparam logic [7:0] OP_LIT0           = 8'h30;
  localparam logic [7:0] OP_LIT31          = 8'h4f;
  localparam logic [7:0] OP_BREG0          = 8'h70;
  localparam logic [7:0] OP_BREG31         = 8'h8f;
  localparam logic [7:0] OP_FBREG          = 8'h91;
  localparam logic [7:0] OP_NOP            = 8'h96;
  localparam logic [7:0] OP_CALL_FRAME_CFA = 8'h9c;

  // fault codes
  localparam logic [FAULT_W-1:0] FAULT_OK    = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_UNDER = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_OVER  = 2'd2;
  localparam logic [FAULT_W-1:0] FAULT_UNSUP = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_ADDR = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOAD_BASE  = 1'd1;

  typedef struct packed {
    logic [7:0]         func;
    logic [VALUE_W-1:0] operand;
    logic [VALUE_W-1:0] supplied_value;
    logic               first;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] top_value;
    logic [COUNT_W-1:0] stack_count;
    logic [FAULT_W-1:0] fault;
  } out_item_t;

endpackage

// File: hw/rtl/dwarf_expression_stack_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwarf_expression_stack_evaluator
// Executes one location-expression operation per transfer on a 64-bit stack.
// ----------------------------------------------------------------------------
// Every operation except mul updates the stack registers directly, so a new
// transfer can be taken on every clock while in_stall is low. The top two
// stack entries live in registers and the rest in a RAM whose next-deeper
// entry is prefetched each cycle. Mul runs through a shared 32x32 multiplier
// in the steps low-low, low-high and high-low. The output has a register
// plus a skid stage; input stall rises only while the multiplier is busy
// or both output stages hold results.
module dwarf_expression_stack_evaluator
  import dses_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]     cfg_data
);

  logic [VALUE_W-1:0] frame_addr;
  logic [VALUE_W-1:0] load_base;
  logic [VALUE_W-1:0] top;
  logic [VALUE_W-1:0] second;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] top_next;
  logic [VALUE_W-1:0] second_next;
  logic [CNT_W-1:0]   cnt_next;
  logic [CNT_W-1:0]   n;

  logic               accept;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr;
  logic [VALUE_W-1:0] rdata;
  logic               fwd_valid;
  logic [VALUE_W-1:0] fwd_data;
  logic [VALUE_W-1:0] third;

  logic               mul_start;
  logic               mul_busy;
  logic               mul_done;
  logic [VALUE_W-1:0] mul_product;

  logic               res_valid;
  out_item_t          res;
  logic [FAULT_W-1:0] fault;
  logic               skid_full;
  out_item_t          skid_item;
  logic               take;

  // decode scratch
  logic [7:0]         op;
  logic [7:0]         lit_idx;
  logic [1:0]         need;
  logic               do_push;
  logic               do_drop;
  logic               do_swap;
  logic               do_bin;
  logic               do_mul;
  logic               do_unary;
  logic               unsup;
  logic [VALUE_W-1:0] push_v;
  logic [VALUE_W-1:0] r;

  assign in_stall = skid_full | mul_busy;
  assign accept   = in_valid & ~in_stall;
  assign take     = out_valid & ~out_stall;
  assign third    = fwd_valid ? fwd_data : rdata;

  always_comb begin
    op       = in_item.func;
    lit_idx  = op - OP_LIT0;
    n        = in_item.first ? '0 : cnt;
    need     = 2'd0;
    do_push  = 1'b0;
    do_drop  = 1'b0;
    do_swap  = 1'b0;
    do_bin   = 1'b0;
    do_mul   = 1'b0;
    do_unary = 1'b0;
    unsup    = 1'b0;
    push_v   = '0;
    r        = '0;

    if (op inside {[OP_BREG0:OP_BREG31]}) begin
      do_push = 1'b1;
      push_v  = in_item.supplied_value + in_item.operand;
    end else if (op inside {[OP_LIT0:OP_LIT31]}) begin
      do_push = 1'b1;
      push_v  = {{(VALUE_W-8){1'b0}}, lit_idx};
    end else if (op inside {[OP_CONST1U:OP_CONSTS]}) begin
      do_push = 1'b1;
      push_v  = in_item.operand;
    end else begin
      case (op)
        OP_CALL_FRAME_CFA: begin
          do_push = 1'b1;
          push_v  = in_item.supplied_value;
        end
        OP_FBREG: begin
          do_push = 1'b1;
          push_v  = frame_addr + in_item.operand;
        end
        OP_ADDR: begin
          do_push = 1'b1;
          push_v  = load_base + in_item.operand;
        end
        OP_NOP: begin
        end
        OP_DUP: begin
          need    = 2'd1;
          do_push = 1'b1;
          push_v  = top;
        end
        OP_OVER: begin
          need    = 2'd2;
          do_push = 1'b1;
          push_v  = second;
        end
        OP_DROP: begin
          need    = 2'd1;
          do_drop = 1'b1;
        end
        OP_SWAP: begin
          need    = 2'd2;
          do_swap = 1'b1;
        end
        OP_PLUS: begin
          need   = 2'd2;
          do_bin = 1'b1;
          r      = second + top;
        end
        OP_MINUS: begin
          need   = 2'd2;
          do_bin = 1'b1;
          r      = second - top;
        end
        OP_AND: begin
          need   = 2'd2;
          do_bin = 1'b1;
          r      = second & top;
        end
        OP_OR: begin
          need   = 2'd2;
          do_bin = 1'b1;
          r      = second | top;
        end
        OP_XOR: begin
          need   = 2'd2;
          do_bin = 1'b1;
          r      = second ^ top;
        end
        OP_MUL: begin
          need   = 2'd2;
          do_mul = 1'b1;
        end
        OP_PLUS_UCONST: begin
          need     = 2'd1;
          do_unary = 1'b1;
          r        = top + in_item.operand;
        end
        OP_NOT: begin
          need     = 2'd1;
          do_unary = 1'b1;
          r        = ~top;
        end
        OP_NEG: begin
          need     = 2'd1;
          do_unary = 1'b1;
          r        = '0 - top;
        end
        default: begin
          unsup = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    top_next    = top;
    second_next = second;
    cnt_next    = cnt;
    we          = 1'b0;
    waddr       = ADDR_W'(n - CNT_W'(2));
    fault       = FAULT_OK;
    mul_start   = 1'b0;
    res_valid   = 1'b0;

    if (mul_done) begin
      top_next  = mul_product;
      res_valid = 1'b1;
    end else if (accept) begin
      cnt_next  = n;
      res_valid = 1'b1;
      if (unsup) begin
        fault = FAULT_UNSUP;
      end else if (n < CNT_W'(need)) begin
        fault = FAULT_UNDER;
      end else if (do_push && (n >= CNT_W'(STACK_DEPTH))) begin
        fault = FAULT_OVER;
      end else if (do_push) begin
        top_next    = push_v;
        second_next = top;
        cnt_next    = n + CNT_W'(1);
        // second spills to the RAM only when it holds a live entry
        we          = (n >= CNT_W'(2));
      end else if (do_drop) begin
        top_next    = second;
        second_next = third;
        cnt_next    = n - CNT_W'(1);
      end else if (do_swap) begin
        top_next    = second;
        second_next = top;
      end else if (do_bin) begin
        top_next    = r;
        second_next = third;
        cnt_next    = n - CNT_W'(1);
      end else if (do_mul) begin
        second_next = third;
        cnt_next    = n - CNT_W'(1);
        mul_start   = 1'b1;
        res_valid   = 1'b0;
      end else if (do_unary) begin
        top_next = r;
      end
    end

    // prefetch the entry that sits below second after this cycle
    raddr = ADDR_W'(cnt_next - CNT_W'(3));

    res.top_value   = (cnt_next != '0) ? top_next : '0;
    res.stack_count = COUNT_W'(cnt_next);
    res.fault       = fault;
  end

  dses_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (second),
    .raddr (raddr),
    .rdata (rdata)
  );

  dses_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (top),
    .b       (second),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (mul_product)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      fwd_valid  <= 1'b0;
      out_valid  <= 1'b0;
      skid_full  <= 1'b0;
      frame_addr <= '0;
      load_base  <= '0;
    end else begin
      cnt       <= cnt_next;
      // read of an address written in the same cycle returns old data
      fwd_valid <= we && (waddr == raddr);
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_ADDR: frame_addr <= cfg_data;
          CFG_LOAD_BASE:  load_base  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (take) begin
        if (skid_full) begin
          skid_full <= res_valid;
        end else begin
          out_valid <= res_valid;
        end
      end else if (!out_valid) begin
        out_valid <= res_valid;
      end else if (res_valid) begin
        skid_full <= 1'b1;
      end
    end
  end

  // stack and result payload
  always_ff @(posedge clk) begin
    top      <= top_next;
    second   <= second_next;
    fwd_data <= second;
    if (take) begin
      if (skid_full) begin
        out_item <= skid_item;
        if (res_valid) begin
          skid_item <= res;
        end
      end else if (res_valid) begin
        out_item <= res;
      end
    end else if (!out_valid) begin
      if (res_valid) begin
        out_item <= res;
      end
    end else if (res_valid) begin
      skid_item <= res;
    end
  end

endmodule

// File: hw/rtl/dses_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dses_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dses_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/dses_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dses_mul
// 64x64 multiplier, low 64 bits, built from one 32x32 product per cycle.
// ----------------------------------------------------------------------------
module dses_mul
  import dses_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] a,
  input  logic [VALUE_W-1:0] b,
  output logic               busy,
  output logic               done,
  output logic [VALUE_W-1:0] product
);

  localparam int HALF_W = VALUE_W / 2;
  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_LH = 2'd1;
  localparam logic [1:0] STEP_HL = 2'd2;

  logic [VALUE_W-1:0] op_a;
  logic [VALUE_W-1:0] op_b;
  logic [VALUE_W-1:0] acc;
  logic [1:0]         step;
  logic [HALF_W-1:0]  mx;
  logic [HALF_W-1:0]  my;
  logic [VALUE_W-1:0] pp;
  logic [VALUE_W-1:0] acc_next;

  always_comb begin
    case (step)
      STEP_LL: begin
        mx = op_a[HALF_W-1:0];
        my = op_b[HALF_W-1:0];
      end
      STEP_LH: begin
        mx = op_a[HALF_W-1:0];
        my = op_b[VALUE_W-1:HALF_W];
      end
      STEP_HL: begin
        mx = op_a[VALUE_W-1:HALF_W];
        my = op_b[HALF_W-1:0];
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
    pp = VALUE_W'(mx) * VALUE_W'(my);
    // cross terms only reach the upper half
    if (step == STEP_LL) begin
      acc_next = pp;
    end else begin
      acc_next = acc + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
    end
  end

  assign done    = busy && (step == STEP_HL);
  assign product = acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_LL;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_LL;
    end else if (busy) begin
      if (done) begin
        busy <= 1'b0;
        step <= STEP_LL;
      end else begin
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_a <= a;
      op_b <= b;
    end
    if (busy) begin
      acc <= acc_next;
    end
  end

endmodule

// File: hw/rtl/dses_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dses_checker
// Port-level checks for the expression stack evaluator, bound to the top.
// ----------------------------------------------------------------------------
module dses_checker
  import dses_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input in_item_t               in_item,
  input logic                   out_valid,
  input logic                   out_stall,
  input out_item_t              out_item
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input transfer changed or dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.stack_count == '0) |-> (out_item.top_value == '0))
    else $error("empty stack with nonzero top value");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.fault == FAULT_OVER)
      |-> (out_item.stack_count == COUNT_W'(STACK_DEPTH)))
    else $error("overflow reported below full depth");

endmodule

bind dwarf_expression_stack_evaluator dses_checker u_dses_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
